@@ rtl/core/ird_pkg.sv @@
package ird_pkg;

   localparam int DEFAULT_DEPTH = 128;
   localparam int WORD_W        = 32;

   typedef enum logic [1:0] {
      REQ_ENQ       = 2'd0,
      REQ_DEQ_FRONT = 2'd1,
      REQ_DEQ_REAR  = 2'd2
   } req_code_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_code_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_LOAD
   } ctrl_state_type;

   typedef struct packed {
      logic capture;
      logic exec;
      logic load_out;
   } ird_cmd_type;

   typedef struct packed {
      logic out_busy;
   } ird_sts_type;

endpackage

@@ rtl/core/ird_if.sv @@
interface ird_req_if import ird_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [1:0]               req_type;
   logic signed [WORD_W-1:0] data_in;

   modport source (output valid, output req_type, output data_in, input ready);
   modport sink   (input valid, input req_type, input data_in, output ready);
endinterface

interface ird_rsp_if import ird_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [WORD_W-1:0] data_out;
   logic [1:0]               status;
   logic                     now_empty;
   logic                     now_full;

   modport source (output valid, output data_out, output status, output now_empty,
                   output now_full, input ready);
   modport sink   (input valid, input data_out, input status, input now_empty,
                   input now_full, output ready);
endinterface

@@ rtl/core/input_restricted_deque_top.sv @@
// Input-restricted deque over a circular store of DEPTH signed 32-bit words.
// Request channel (req_if): req_type selects enqueue at the rear, dequeue
// from the front or dequeue from the rear; data_in is the word to enqueue.
// Result channel (rsp_if): one beat per request with data_out, status
// (ok, full, empty) and the now_empty / now_full flags after the request.
// A refused dequeue returns -1, an enqueue returns 0; code 3 does nothing.
// Each request runs through the controller's capture, execute and load
// steps in that order, and its result is then held in the output register;
// a new request is taken only after the last one has left the load step.
// The store is a memory with a registered read.
// The result sits in an output register; a request may be taken while it
// waits. If the receiver stalls, the next result holds in the load step
// and no further request is taken until the register frees.
// Reset (synchronous, active high) empties the deque and drops any pending
// result; the store itself is not cleared.
module input_restricted_deque_top import ird_pkg::*; #(
   parameter int DEPTH = DEFAULT_DEPTH
) (
   input  logic   clock,
   input  logic   reset,
   ird_req_if.sink   req_if,
   ird_rsp_if.source rsp_if
);

   ird_cmd_type cmd;
   ird_sts_type sts;

   ird_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   ird_dpath #(
      .DEPTH (DEPTH)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .req_type  (req_if.req_type),
      .data_in   (req_if.data_in),
      .rsp_ready (rsp_if.ready),
      .rsp_valid (rsp_if.valid),
      .data_out  (rsp_if.data_out),
      .status    (rsp_if.status),
      .now_empty (rsp_if.now_empty),
      .now_full  (rsp_if.now_full)
   );

endmodule

@@ rtl/core/ird_ctrl.sv @@
module ird_ctrl import ird_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  ird_sts_type sts,
   output ird_cmd_type cmd
);

   ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_EXEC;
            end
         end
         S_EXEC: begin
            cmd.exec = 1'b1;
            state_in = S_LOAD;
         end
         S_LOAD: begin
            // hold until the output register is free
            if (!sts.out_busy) begin
               cmd.load_out = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

@@ rtl/core/ird_dpath.sv @@
module ird_dpath import ird_pkg::*; #(
   parameter int DEPTH = DEFAULT_DEPTH
) (
   input  logic                     clock,
   input  logic                     reset,
   input  ird_cmd_type              cmd,
   output ird_sts_type              sts,
   input  logic [1:0]               req_type,
   input  logic signed [WORD_W-1:0] data_in,
   input  logic                     rsp_ready,
   output logic                     rsp_valid,
   output logic signed [WORD_W-1:0] data_out,
   output logic [1:0]               status,
   output logic                     now_empty,
   output logic                     now_full
);

   localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

   logic [WORD_W-1:0] mem [DEPTH];
   logic [WORD_W-1:0] rd_data_ff;

   logic [1:0]               req_ff;
   logic signed [WORD_W-1:0] word_ff;
   logic [IW-1:0]            front_ff, front_in;
   logic [IW-1:0]            rear_ff, rear_in;
   logic [CW-1:0]            count_ff, count_in;
   logic [1:0]               pend_status_ff, pend_status_in;
   logic                     pend_mem_ff, pend_mem_in;
   logic                     out_valid_ff, out_valid_in;
   logic signed [WORD_W-1:0] out_data_ff;
   logic [1:0]               out_status_ff;
   logic                     out_empty_ff, out_full_ff;

   logic          wr_en, rd_en;
   logic [IW-1:0] wr_addr, rd_addr;
   logic          no_items, is_full;

   function automatic logic [IW-1:0] wrap_up(input logic [IW-1:0] i);
      return (i == LAST_IDX) ? '0 : i + IW'(1);
   endfunction

   function automatic logic [IW-1:0] wrap_down(input logic [IW-1:0] i);
      return (i == '0) ? LAST_IDX : i - IW'(1);
   endfunction

   assign no_items = (count_ff == '0);
   assign is_full  = (count_ff >= FULL_CNT);

   always_comb begin
      front_in       = front_ff;
      rear_in        = rear_ff;
      count_in       = count_ff;
      pend_status_in = pend_status_ff;
      pend_mem_in    = pend_mem_ff;
      wr_en          = 1'b0;
      rd_en          = 1'b0;
      wr_addr        = no_items ? '0 : wrap_up(rear_ff);
      rd_addr        = (req_ff == REQ_DEQ_FRONT) ? front_ff : rear_ff;
      if (cmd.exec) begin
         pend_status_in = ST_OK;
         pend_mem_in    = 1'b0;
         case (req_ff)
            REQ_ENQ: begin
               if (is_full) begin
                  pend_status_in = ST_FULL;
               end else begin
                  wr_en    = 1'b1;
                  rear_in  = wr_addr;
                  front_in = no_items ? '0 : front_ff;
                  count_in = count_ff + CW'(1);
               end
            end
            REQ_DEQ_FRONT, REQ_DEQ_REAR: begin
               if (no_items) begin
                  pend_status_in = ST_EMPTY;
               end else begin
                  rd_en       = 1'b1;
                  pend_mem_in = 1'b1;
                  count_in    = count_ff - CW'(1);
                  if (count_ff == CW'(1)) begin
                     front_in = '0;
                     rear_in  = '0;
                  end else if (req_ff == REQ_DEQ_FRONT) begin
                     front_in = wrap_up(front_ff);
                  end else begin
                     rear_in = wrap_down(rear_ff);
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= word_ff;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff  <= req_type;
         word_ff <= data_in;
      end
      pend_status_ff <= pend_status_in;
      pend_mem_ff    <= pend_mem_in;
      if (cmd.load_out) begin
         out_status_ff <= pend_status_ff;
         out_empty_ff  <= no_items;
         out_full_ff   <= is_full;
         if (pend_mem_ff) begin
            out_data_ff <= $signed(rd_data_ff);
         end else if (pend_status_ff == ST_EMPTY) begin
            out_data_ff <= -WORD_W'(1);
         end else begin
            out_data_ff <= '0;
         end
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff && !rsp_ready;
      if (cmd.load_out) begin
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff     <= '0;
         rear_ff      <= '0;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         front_ff     <= front_in;
         rear_ff      <= rear_in;
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign sts.out_busy = out_valid_ff && !rsp_ready;
   assign rsp_valid    = out_valid_ff;
   assign data_out     = out_data_ff;
   assign status       = out_status_ff;
   assign now_empty    = out_empty_ff;
   assign now_full     = out_full_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_CNT)
      else $error("occupancy beyond depth");

   a_empty_idx: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (front_ff == '0 && rear_ff == '0))
      else $error("indices not parked while empty");

   a_full_flag: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_status_ff == ST_FULL) |-> out_full_ff)
      else $error("refused enqueue without full flag");

   a_empty_result: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_status_ff == ST_EMPTY) |-> (out_empty_ff && out_data_ff == -1))
      else $error("refused dequeue result malformed");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (cmd.load_out) |-> !(out_valid_ff && !rsp_ready))
      else $error("output register overwritten before taken");

endmodule
